>>> rtl/rmts_pkg.sv
// ============================================================================
// rmts_pkg: shared types and constants of the rate-monotonic tick scheduler
// Holds the field widths, the operation codes, the idle priority value and
// the control structs that pass between the table, the evaluation unit and
// the sequencer.
// ============================================================================
package rmts_pkg;

    localparam int TIME_W   = 32;
    localparam int ID_W     = 8;
    localparam int PERIOD_W = 16;
    localparam int BURST_W  = 16;
    localparam int COUNT_W  = 4;
    localparam int INDEX_W  = 3;
    localparam int BEST_W   = 17;

    // Operation codes carried by the func field.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Priority value that any real period beats.
    localparam logic [BEST_W-1:0] NO_PERIOD = 17'd99999;

    // Write command for the task table. At most one flag is set per cycle.
    typedef struct packed {
        logic load;       // write a whole entry
        logic rerelease;  // write release time and remaining work
        logic decrement;  // write remaining work only
    } table_wr_t;

    // Status from the evaluation unit for the entry under test.
    typedef struct packed {
        logic due;        // release time reached and task arrived
        logic eligible;   // arrived with work left after any refill
        logic better;     // eligible and period beats the best so far
    } eval_res_t;

endpackage

>>> rtl/rmts_task_table.sv
// ============================================================================
// rmts_task_table: task entry storage
// One register row per task entry, written through a single command port and
// read at one address chosen by the sequencer.
// ============================================================================
module rmts_task_table #(
    parameter int TASKS = 8,
    parameter int IDX_W = 3
) (
    input  logic                           clk,
    input  rmts_pkg::table_wr_t            wr,
    input  logic [IDX_W-1:0]               wr_idx,
    input  logic [rmts_pkg::ID_W-1:0]      wr_id,
    input  logic [rmts_pkg::TIME_W-1:0]    wr_arrival,
    input  logic [rmts_pkg::PERIOD_W-1:0]  wr_period,
    input  logic [rmts_pkg::BURST_W-1:0]   wr_burst,
    input  logic [rmts_pkg::TIME_W-1:0]    wr_release,
    input  logic [rmts_pkg::BURST_W-1:0]   wr_work,
    input  logic [IDX_W-1:0]               rd_idx,
    output logic [rmts_pkg::ID_W-1:0]      rd_id,
    output logic [rmts_pkg::TIME_W-1:0]    rd_arrival,
    output logic [rmts_pkg::PERIOD_W-1:0]  rd_period,
    output logic [rmts_pkg::BURST_W-1:0]   rd_burst,
    output logic [rmts_pkg::TIME_W-1:0]    rd_release,
    output logic [rmts_pkg::BURST_W-1:0]   rd_work
);
    import rmts_pkg::*;

    logic [ID_W-1:0]     id_reg      [TASKS];
    logic [TIME_W-1:0]   arrival_reg [TASKS];
    logic [PERIOD_W-1:0] period_reg  [TASKS];
    logic [BURST_W-1:0]  burst_reg   [TASKS];
    logic [TIME_W-1:0]   release_reg [TASKS];
    logic [BURST_W-1:0]  work_reg    [TASKS];

    // Entries hold no reset value; they are defined once loaded.
    always_ff @(posedge clk)
    begin
        if (wr.load)
        begin
            id_reg[wr_idx]      <= wr_id;
            arrival_reg[wr_idx] <= wr_arrival;
            period_reg[wr_idx]  <= wr_period;
            burst_reg[wr_idx]   <= wr_burst;
        end
        if (wr.load || wr.rerelease)
        begin
            release_reg[wr_idx] <= wr_release;
        end
        if (wr.load || wr.rerelease || wr.decrement)
        begin
            work_reg[wr_idx] <= wr_work;
        end
    end

    assign rd_id      = id_reg[rd_idx];
    assign rd_arrival = arrival_reg[rd_idx];
    assign rd_period  = period_reg[rd_idx];
    assign rd_burst   = burst_reg[rd_idx];
    assign rd_release = release_reg[rd_idx];
    assign rd_work    = work_reg[rd_idx];

endmodule

>>> rtl/rmts_eval_unit.sv
// ============================================================================
// rmts_eval_unit: shared release and priority evaluation
// Tests one task entry per cycle: release check, release advance, work refill
// and the priority compare. A load reuses the same adder for its first
// release time.
// ============================================================================
module rmts_eval_unit (
    input  logic                                 load_mode,
    input  logic [rmts_pkg::TIME_W-1:0]          cur_tick,
    input  logic [rmts_pkg::TIME_W-1:0]          e_arrival,
    input  logic [rmts_pkg::TIME_W-1:0]          e_release,
    input  logic [rmts_pkg::PERIOD_W-1:0]        e_period,
    input  logic [rmts_pkg::BURST_W-1:0]         e_burst,
    input  logic [rmts_pkg::BURST_W-1:0]         e_work,
    input  logic [rmts_pkg::BEST_W-1:0]          best_period,
    output rmts_pkg::eval_res_t                  res,
    output logic [rmts_pkg::TIME_W-1:0]          new_release,
    output logic [rmts_pkg::BURST_W-1:0]         new_work
);
    import rmts_pkg::*;

    logic                arrived;
    logic                reached;
    logic [TIME_W-1:0]   add_base;

    assign arrived = (e_arrival <= cur_tick);
    assign reached = (cur_tick >= e_release);

    // A load starts from the arrival time, a re-release from the old release.
    assign add_base    = load_mode ? e_arrival : e_release;
    assign new_release = add_base + TIME_W'(e_period);

    assign res.due      = !load_mode && reached && arrived;
    assign new_work     = (load_mode || res.due) ? e_burst : e_work;
    assign res.eligible = !load_mode && arrived && (new_work != '0);
    assign res.better   = res.eligible && ({1'b0, e_period} < best_period);

endmodule

>>> rtl/rate_monotonic_tick_scheduler_unit.sv
// ============================================================================
// rate_monotonic_tick_scheduler_unit: periodic task table with rate-monotonic
// selection
// Load transactions fill task entries; tick transactions re-release due tasks,
// run the arrived task with the shortest period and report it, or idle.
// ============================================================================
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-----------------------------------------
//  in       | in_valid / in_stall    | func, task_index, task_id, task_arrival,
//           |                        | task_period, task_burst
//  out      | out_valid / out_stall  | tick_time, run_valid, run_id, run_index
//  cfg      | cfg_we                 | cfg_wdata (task_count)
//
//  A load transaction is written in the cycle it is accepted and produces no
//  result. A tick transaction passes through an accept step, a scan of the
//  entries in use, one at a time through the shared evaluation unit, and a
//  final step that retires the result and updates the winner's remaining
//  work. The input stalls while a tick is in progress; a result waiting in the
//  output register does not stall the input, but the next tick holds in its
//  final step until that register is free. Reset clears the tick counter,
//  task_count and all control state; table entries are undefined until
//  loaded.
//
module rate_monotonic_tick_scheduler_unit #(
    parameter int TASKS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rmts_pkg::COUNT_W-1:0]         cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 func,
    input  logic [rmts_pkg::INDEX_W-1:0]         task_index,
    input  logic [rmts_pkg::ID_W-1:0]            task_id,
    input  logic [rmts_pkg::TIME_W-1:0]          task_arrival,
    input  logic [rmts_pkg::PERIOD_W-1:0]        task_period,
    input  logic [rmts_pkg::BURST_W-1:0]         task_burst,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rmts_pkg::TIME_W-1:0]          tick_time,
    output logic                                 run_valid,
    output logic [rmts_pkg::ID_W-1:0]            run_id,
    output logic [rmts_pkg::INDEX_W-1:0]         run_index
);
    import rmts_pkg::*;

    localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CNT_W = $clog2(TASKS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [TIME_W-1:0]   tick_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    sel_reg, sel_next;
    logic                found_reg, found_next;
    logic [BEST_W-1:0]   best_reg, best_next;
    logic [BURST_W-1:0]  best_work_reg, best_work_next;
    logic [ID_W-1:0]     best_id_reg, best_id_next;

    logic                out_valid_reg;
    logic [TIME_W-1:0]   tick_time_reg;
    logic                run_valid_reg;
    logic [ID_W-1:0]     run_id_reg;
    logic [INDEX_W-1:0]  run_index_reg;

    logic [CNT_W-1:0]    n_active;
    logic                in_accept;
    logic                load_accept;
    logic                load_ok;
    logic                tick_accept;
    logic                scan_last;
    logic                retire;

    table_wr_t           tbl_wr;
    logic [IDX_W-1:0]    tbl_wr_idx;
    logic [BURST_W-1:0]  tbl_wr_work;
    logic [ID_W-1:0]     rd_id;
    logic [TIME_W-1:0]   rd_arrival;
    logic [PERIOD_W-1:0] rd_period;
    logic [BURST_W-1:0]  rd_burst;
    logic [TIME_W-1:0]   rd_release;
    logic [BURST_W-1:0]  rd_work;

    logic [TIME_W-1:0]   ev_arrival;
    logic [PERIOD_W-1:0] ev_period;
    logic [BURST_W-1:0]  ev_burst;
    eval_res_t           ev_res;
    logic [TIME_W-1:0]   ev_release;
    logic [BURST_W-1:0]  ev_work;

    // Entries beyond the table size are never scanned.
    assign n_active = (32'(count_reg) > TASKS) ? CNT_W'(TASKS) : CNT_W'(count_reg);

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign load_ok     = (32'(task_index) < TASKS);
    assign load_accept = in_accept && (func == FUNC_LOAD) && load_ok;
    assign tick_accept = in_accept && (func == FUNC_TICK);
    assign scan_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == n_active);

    // The result register must be free (or emptying) before a tick retires.
    assign retire = (state_reg == ST_DONE) && !(out_valid_reg && out_stall);

    // ------------------------------------------------------------------
    // Shared evaluation unit. While idle it serves a load transaction
    // (first release = arrival + period); during a scan it serves the
    // table entry under the scan index.
    // ------------------------------------------------------------------
    assign ev_arrival = (state_reg == ST_IDLE) ? task_arrival : rd_arrival;
    assign ev_period  = (state_reg == ST_IDLE) ? task_period  : rd_period;
    assign ev_burst   = (state_reg == ST_IDLE) ? task_burst   : rd_burst;

    rmts_eval_unit u_eval (
        .load_mode   (state_reg == ST_IDLE),
        .cur_tick    (tick_reg),
        .e_arrival   (ev_arrival),
        .e_release   (rd_release),
        .e_period    (ev_period),
        .e_burst     (ev_burst),
        .e_work      (rd_work),
        .best_period (best_reg),
        .res         (ev_res),
        .new_release (ev_release),
        .new_work    (ev_work)
    );

    // ------------------------------------------------------------------
    // Table write command: load while idle, re-release during the scan,
    // decrement of the winner when the tick retires.
    // ------------------------------------------------------------------
    always_comb
    begin
        tbl_wr           = '0;
        tbl_wr.load      = load_accept;
        tbl_wr.rerelease = (state_reg == ST_SCAN) && ev_res.due;
        tbl_wr.decrement = retire && found_reg;
        tbl_wr_idx       = idx_reg;
        tbl_wr_work      = ev_work;
        unique case (state_reg)
            ST_IDLE:
            begin
                tbl_wr_idx = IDX_W'(task_index);
            end
            ST_DONE:
            begin
                tbl_wr_idx  = sel_reg;
                tbl_wr_work = best_work_reg - BURST_W'(1);
            end
            default:
            begin
                tbl_wr_idx = idx_reg;
            end
        endcase
    end

    rmts_task_table #(
        .TASKS (TASKS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk        (clk),
        .wr         (tbl_wr),
        .wr_idx     (tbl_wr_idx),
        .wr_id      (task_id),
        .wr_arrival (task_arrival),
        .wr_period  (task_period),
        .wr_burst   (task_burst),
        .wr_release (ev_release),
        .wr_work    (tbl_wr_work),
        .rd_idx     (idx_reg),
        .rd_id      (rd_id),
        .rd_arrival (rd_arrival),
        .rd_period  (rd_period),
        .rd_burst   (rd_burst),
        .rd_release (rd_release),
        .rd_work    (rd_work)
    );

    // ------------------------------------------------------------------
    // Sequencer. Re-release and selection for an entry happen in the same
    // cycle: a refill only touches its own entry, so the selection sees
    // exactly the post-refill work of every entry.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        sel_next       = sel_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_work_next = best_work_reg;
        best_id_next   = best_id_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_accept)
                begin
                    idx_next   = '0;
                    sel_next   = '0;
                    found_next = 1'b0;
                    best_next  = NO_PERIOD;
                    state_next = (n_active == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ev_res.better)
                begin
                    best_next      = {1'b0, rd_period};
                    sel_next       = idx_reg;
                    found_next     = 1'b1;
                    best_work_next = ev_work;
                    best_id_next   = rd_id;
                end
                if (scan_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (retire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            tick_reg      <= '0;
            idx_reg       <= '0;
            sel_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sel_reg   <= sel_next;
            found_reg <= found_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (retire)
            begin
                tick_reg      <= tick_reg + TIME_W'(1);
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        best_work_reg <= best_work_next;
        best_id_reg   <= best_id_next;
        if (retire)
        begin
            tick_time_reg <= tick_reg;
            run_valid_reg <= found_reg;
            run_id_reg    <= found_reg ? best_id_reg : '0;
            run_index_reg <= found_reg ? INDEX_W'(sel_reg) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign tick_time = tick_time_reg;
    assign run_valid = run_valid_reg;
    assign run_id    = run_id_reg;
    assign run_index = run_index_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Each retired tick advances the tick counter by exactly one.
    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        retire |=> (tick_reg == $past(tick_reg) + TIME_W'(1)))
        else $error("tick counter did not advance on retire");

    // The scan index never runs past the entries in use.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(idx_reg) < n_active))
        else $error("scan index beyond active entries");

    // A new result only appears when a tick retires.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(retire))
        else $error("result raised without a retiring tick");

    // A selected task always carries a real period and work to consume.
    a_found_sane: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && found_reg) |->
            ((best_reg < NO_PERIOD) && (best_work_reg != '0)))
        else $error("selected task has no period or no work");

    // A retire that overwrites the result register never drops a held result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(tick_time_reg))
        else $error("held result was overwritten");

endmodule

>>> dv/rate_monotonic_tick_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// rate_monotonic_tick_scheduler_unit_tb: self-checking bench for the scheduler
// A queue of load and tick transactions feeds a clocked driver. A scheduler
// model that runs beside the block predicts every tick result, and a clocked
// monitor compares each result the block delivers against the oldest
// prediction. The stimulus is a short directed run followed by random phases,
// each of which sets task_count and the idle and stall pattern anew.
// ============================================================================
module rate_monotonic_tick_scheduler_unit_tb;

    import rmts_pkg::*;

    localparam int TABLE_SIZE    = 8;
    localparam int CYCLE_LIMIT   = 600000;
    // Covers the longest tick: the accept step, a scan of all eight entries and the retire step.
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 225;
    // Percentage of random transactions that load an entry rather than tick.
    localparam int LOAD_SHARE    = 15;

    // One input transaction as it is presented to the block.
    typedef struct {
        logic                func;
        logic [INDEX_W-1:0]  index;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   arrival;
        logic [PERIOD_W-1:0] period;
        logic [BURST_W-1:0]  burst;
    } task_item_t;

    // One tick report as the block should deliver it.
    typedef struct {
        logic [TIME_W-1:0]  tick_time;
        logic               run_valid;
        logic [ID_W-1:0]    run_id;
        logic [INDEX_W-1:0] run_index;
    } tick_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                func = FUNC_LOAD;
    logic [INDEX_W-1:0]  task_index = '0;
    logic [ID_W-1:0]     task_id = '0;
    logic [TIME_W-1:0]   task_arrival = '0;
    logic [PERIOD_W-1:0] task_period = '0;
    logic [BURST_W-1:0]  task_burst = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [TIME_W-1:0]   tick_time;
    logic                run_valid;
    logic [ID_W-1:0]     run_id;
    logic [INDEX_W-1:0]  run_index;

    task_item_t   pending_items[$];
    tick_report_t expected_reports[$];

    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    // Tick number that the next queued tick transaction will carry. Arrival
    // times of well-formed loads are placed around it so that tasks run.
    logic [TIME_W-1:0] queued_ticks = '0;

    // Scheduler state kept by the bench: the task table, the tick counter
    // and the task_count register.
    logic [ID_W-1:0]     sched_id[TABLE_SIZE];
    logic [TIME_W-1:0]   sched_arrival[TABLE_SIZE];
    logic [PERIOD_W-1:0] sched_period[TABLE_SIZE];
    logic [BURST_W-1:0]  sched_burst[TABLE_SIZE];
    logic [TIME_W-1:0]   sched_release[TABLE_SIZE];
    logic [BURST_W-1:0]  sched_work[TABLE_SIZE];
    logic [TIME_W-1:0]   sched_tick = '0;
    logic [COUNT_W-1:0]  sched_count = '0;

    rate_monotonic_tick_scheduler_unit #(
        .TASKS(TABLE_SIZE)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .task_index  (task_index),
        .task_id     (task_id),
        .task_arrival(task_arrival),
        .task_period (task_period),
        .task_burst  (task_burst),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tick_time   (tick_time),
        .run_valid   (run_valid),
        .run_id      (run_id),
        .run_index   (run_index)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Any run that outlives this many cycles has hung somewhere.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rate_monotonic_tick_scheduler_unit test failed");
            $finish;
        end
    end

    // The driver offers a new transaction only when the previous one has been
    // taken or none is on the bus, so a stalled payload never moves. The
    // sender idles at random at exactly those points.
    always @(posedge clk)
    begin : item_driver
        task_item_t next_item;
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                next_item = pending_items.pop_front();
                in_valid     <= 1'b1;
                func         <= next_item.func;
                task_index   <= next_item.index;
                task_id      <= next_item.id;
                task_arrival <= next_item.arrival;
                task_period  <= next_item.period;
                task_burst   <= next_item.burst;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random; the rate is set per phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Scheduler model. It follows every register write and every accepted
    // transaction at the same clock edge the block sees them. A load rewrites
    // one entry and arms its first release one period after arrival. A tick
    // first refills every due entry that has arrived, then runs the arrived
    // entry with work left and the shortest period, where a strict compare
    // lets the lowest index keep a tie.
    always @(posedge clk)
    begin : scheduler_model
        tick_report_t      report;
        int                active;
        logic [BEST_W-1:0] best_period;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                sched_count = cfg_wdata;
            end
            if (in_valid && !in_stall)
            begin
                if (func == FUNC_LOAD)
                begin
                    sched_id[task_index]      = task_id;
                    sched_arrival[task_index] = task_arrival;
                    sched_period[task_index]  = task_period;
                    sched_burst[task_index]   = task_burst;
                    sched_release[task_index] = task_arrival + TIME_W'(task_period);
                    sched_work[task_index]    = task_burst;
                end
                else
                begin
                    // A count beyond the table size covers the whole table.
                    active = (int'(sched_count) > TABLE_SIZE) ? TABLE_SIZE
                                                              : int'(sched_count);
                    for (int e = 0; e < active; e++)
                    begin
                        // An overrun is simply lost: the refill overwrites it.
                        if (sched_tick >= sched_release[e] && sched_arrival[e] <= sched_tick)
                        begin
                            sched_work[e]    = sched_burst[e];
                            sched_release[e] = sched_release[e] + TIME_W'(sched_period[e]);
                        end
                    end
                    report.tick_time = sched_tick;
                    report.run_valid = 1'b0;
                    report.run_id    = '0;
                    report.run_index = '0;
                    best_period      = NO_PERIOD;
                    for (int e = 0; e < active; e++)
                    begin
                        if (sched_work[e] != '0 && sched_arrival[e] <= sched_tick &&
                            BEST_W'(sched_period[e]) < best_period)
                        begin
                            best_period      = BEST_W'(sched_period[e]);
                            report.run_valid = 1'b1;
                            report.run_id    = sched_id[e];
                            report.run_index = INDEX_W'(e);
                        end
                    end
                    if (report.run_valid)
                    begin
                        sched_work[report.run_index] = sched_work[report.run_index]
                                                       - BURST_W'(1);
                    end
                    expected_reports.push_back(report);
                    sched_tick = sched_tick + TIME_W'(1);
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Every delivered result is matched against the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        tick_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, %s %0h run %0b id %0h idx %0h",
                         $time, "actual tick", tick_time, run_valid, run_id, run_index);
                error_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("tick_time", want.tick_time, tick_time);
                check_field("run_valid", 32'(want.run_valid), 32'(run_valid));
                check_field("run_id", 32'(want.run_id), 32'(run_id));
                check_field("run_index", 32'(want.run_index), 32'(run_index));
            end
        end
    end

    task automatic queue_load(input logic [INDEX_W-1:0] index, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] arrival,
                              input logic [PERIOD_W-1:0] period,
                              input logic [BURST_W-1:0] burst);
        task_item_t item;
        item.func    = FUNC_LOAD;
        item.index   = index;
        item.id      = id;
        item.arrival = arrival;
        item.period  = period;
        item.burst   = burst;
        pending_items.push_back(item);
    endtask

    // The block ignores the other fields of a tick, so they carry noise.
    task automatic queue_tick();
        task_item_t item;
        item.func    = FUNC_TICK;
        item.index   = INDEX_W'($urandom);
        item.id      = ID_W'($urandom);
        item.arrival = $urandom;
        item.period  = PERIOD_W'($urandom);
        item.burst   = BURST_W'($urandom);
        pending_items.push_back(item);
        queued_ticks = queued_ticks + TIME_W'(1);
    endtask

    // Returns once every queued transaction has been taken, every result has
    // arrived and a trailing load has certainly been written.
    task automatic wait_until_idle();
        while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_task_count(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // A random phase is mostly ticks with occasional reloads. Most loads are
    // well formed: arrival close to the current tick, short periods and small
    // bursts, so that tasks preempt each other and overrun. The rest use the
    // full field ranges, including a zero period and a zero burst.
    task automatic random_phase(input logic [COUNT_W-1:0] count, input int idle_pct,
                                input int stall_pct);
        logic [TIME_W-1:0]   arrival;
        logic [PERIOD_W-1:0] period;
        logic [BURST_W-1:0]  burst;
        int                  pick;
        int                  k;
        write_task_count(count);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            if ($urandom_range(0, 99) < LOAD_SHARE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    arrival = queued_ticks + $urandom_range(0, 40);
                else if (pick < 80)
                    arrival = queued_ticks - $urandom_range(0, 40);
                else
                    arrival = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    period = '0;
                else if (pick < 60)
                    period = PERIOD_W'($urandom_range(1, 24));
                else if (pick < 80)
                    period = PERIOD_W'($urandom_range(25, 300));
                else
                    period = PERIOD_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    burst = '0;
                else if (pick < 85)
                    burst = BURST_W'($urandom_range(1, 12));
                else
                    burst = BURST_W'($urandom);
                queue_load(INDEX_W'($urandom), ID_W'($urandom), arrival, period, burst);
            end
            else
            begin
                queue_tick();
            end
        end
        wait_until_idle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // With task_count still zero a tick reads no entry and reports idle.
        // All eight entries are then loaded before any tick can look at them.
        queue_tick();
        // Entries 0 and 1 share a period, so the lower index must win the tie.
        queue_load(3'd0, 8'hFF, 32'd0, 16'd4, 16'd1);
        queue_load(3'd1, 8'h00, 32'd0, 16'd4, 16'd2);
        // Longest period and largest burst: lowest priority, never runs dry.
        queue_load(3'd2, 8'hA5, 32'd2, 16'hFFFF, 16'hFFFF);
        // Arrival at the top of the time range: the release sum wraps to a
        // small value, but the task never arrives and so never runs.
        queue_load(3'd3, 8'h5A, 32'hFFFF_FFFF, 16'd16, 16'd3);
        // No work per period: the entry is refilled but never picked.
        queue_load(3'd4, 8'h11, 32'd5, 16'd3, 16'd0);
        // Burst longer than the period: leftover work is dropped at refill.
        queue_load(3'd5, 8'h22, 32'd3, 16'd2, 16'd5);
        queue_load(3'd6, 8'h33, 32'h8000_0000, 16'd7, 16'd1);
        queue_load(3'd7, 8'h44, 32'd6, 16'h8000, 16'h8000);
        wait_until_idle();
        write_task_count(4'd8);
        repeat (8) queue_tick();
        // A zero period never advances the release time, so the entry is
        // refilled on every tick and, holding the best possible period, runs
        // on every tick until it is reloaded.
        queue_load(3'd4, 8'h11, queued_ticks, 16'd0, 16'd2);
        repeat (4) queue_tick();
        queue_load(3'd4, 8'h11, queued_ticks, 16'd9, 16'd1);
        repeat (3) queue_tick();
        wait_until_idle();

        // Random phases walk through task_count settings, the extremes and a
        // count above the table size among them, and through the idle and
        // stall patterns, including stretches with neither.
        random_phase(4'd8, 0, 0);
        random_phase(4'd3, 84, 0);
        random_phase(4'd15, 0, 84);
        random_phase(4'd0, 12, 12);
        random_phase(4'd1, 0, 0);
        random_phase(4'd12, 84, 0);
        random_phase(4'd5, 0, 84);
        random_phase(4'd8, 12, 12);

        if (error_count == 0)
        begin
            $display("rate_monotonic_tick_scheduler_unit test passed");
        end
        else
        begin
            $display("rate_monotonic_tick_scheduler_unit test failed");
        end
        $finish;
    end

endmodule
